// ===== hdl/mdb_pkg.sv =====
package mdb_pkg;

  localparam int unsigned RAW_W       = 32;
  localparam int unsigned PCM_W       = 16;
  localparam int unsigned FB_W        = 32;
  localparam int unsigned FB_SHIFT    = 8;
  localparam int unsigned DECIM_W     = 5;
  localparam int          PCM_MAX     = 32767;
  localparam int          PCM_MIN     = -32768;
  localparam logic [DECIM_W-1:0] DECIM_RESET = 5'd2;
  localparam logic        ACT_CLEAR   = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [RAW_W-1:0] raw_word;
  } in_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    decim_valid;
    logic signed [PCM_W-1:0] decim_sample;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic filt;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic grp_done;
  } stat_t;

endpackage

// ===== hdl/mdb_datapath.sv =====
module mdb_datapath import mdb_pkg::*; #(
  parameter int unsigned MAX_DECIM = 16,
  parameter int unsigned SUM_W     = 21,
  parameter int unsigned CNT_W     = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [DECIM_W-1:0] cfg_data_i,
  input  in_t                in_data_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  output out_t               out_data_o
);

  logic [DECIM_W-1:0]      factor_q;
  logic signed [PCM_W-1:0] prev_in_q;
  logic signed [FB_W-1:0]  prev_out_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]        count_q;

  logic signed [PCM_W-1:0] pcm_q;
  logic                    dvalid_q;
  logic [SUM_W-1:0]        quo_q;
  logic [CNT_W-1:0]        rem_q;
  logic [CNT_W-1:0]        div_q;
  logic                    neg_q;
  out_t                    out_q;

  logic signed [PCM_W-1:0] pcm_w;
  logic signed [FB_W-1:0]  y_w;
  logic signed [PCM_W-1:0] filt_w;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        cnt_next;
  logic [CNT_W-1:0]        eff_w;
  logic [CNT_W:0]          rem_sh;
  logic [SUM_W-1:0]        avg_w;

  assign pcm_w = in_data_i.raw_word[RAW_W-1 -: PCM_W];
  assign y_w   = FB_W'(pcm_w) - FB_W'(prev_in_q) + prev_out_q - (prev_out_q >>> FB_SHIFT);

  always_comb begin
    if (y_w > FB_W'(PCM_MAX)) begin
      filt_w = PCM_W'(PCM_MAX);
    end else if (y_w < FB_W'(PCM_MIN)) begin
      filt_w = PCM_W'(PCM_MIN);
    end else begin
      filt_w = y_w[PCM_W-1:0];
    end
  end

  always_comb begin
    if (factor_q == '0) begin
      eff_w = CNT_W'(1);
    end else if (CNT_W'(factor_q) > CNT_W'(MAX_DECIM)) begin
      eff_w = CNT_W'(MAX_DECIM);
    end else begin
      eff_w = CNT_W'(factor_q);
    end
  end

  assign sum_next = sum_q + SUM_W'(filt_w);
  assign cnt_next = count_q + CNT_W'(1);
  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign avg_w    = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

  assign stat_o.is_clear = (in_data_i.action == ACT_CLEAR);
  assign stat_o.grp_done = (cnt_next >= eff_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q   <= DECIM_RESET;
      prev_in_q  <= '0;
      prev_out_q <= '0;
      sum_q      <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        factor_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        prev_in_q  <= '0;
        prev_out_q <= '0;
        sum_q      <= '0;
        count_q    <= '0;
      end else if (cmd_i.filt) begin
        prev_in_q  <= pcm_w;
        prev_out_q <= y_w;
        if (stat_o.grp_done) begin
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          sum_q   <= sum_next;
          count_q <= cnt_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      pcm_q    <= '0;
      dvalid_q <= 1'b0;
      quo_q    <= '0;
      neg_q    <= 1'b0;
    end else if (cmd_i.filt) begin
      pcm_q    <= pcm_w;
      dvalid_q <= stat_o.grp_done;
      rem_q    <= '0;
      div_q    <= cnt_next;
      if (stat_o.grp_done) begin
        neg_q <= sum_next[SUM_W-1];
        quo_q <= sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
      end else begin
        neg_q <= 1'b0;
        quo_q <= '0;
      end
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_q <= CNT_W'(rem_sh - {1'b0, div_q});
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      out_q.pcm_sample   <= pcm_q;
      out_q.decim_valid  <= dvalid_q;
      out_q.decim_sample <= avg_w[PCM_W-1:0];
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/mdb_ctrl.sv =====
module mdb_ctrl import mdb_pkg::*; #(
  parameter int unsigned SUM_W = 21
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam int unsigned ITR_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  state_e           state_q, state_d;
  logic [ITR_W-1:0] itr_q, itr_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      itr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      itr_q       <= itr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    itr_d      = itr_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        itr_d      = '0;
        if (in_valid_i) begin
          if (stat_i.is_clear) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_OUT;
          end else begin
            cmd_o.filt = 1'b1;
            state_d    = stat_i.grp_done ? ST_DIV : ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        itr_d          = itr_q + ITR_W'(1);
        if (itr_q == ITR_W'(SUM_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_out;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/mic_dc_block_decimator.sv =====
// Microphone DC blocker with boxcar decimator.
// Input beat (valid/ready): action and a 32-bit MSB-aligned slot word. Action
// clear resets filter and accumulator; otherwise the upper 16 bits become PCM,
// run through y = x - x1 + y1 - (y1 >>> 8) and are summed into the group.
// Config beat: decim_factor (5 bits, reset 2), clamped to 1..MAX_DECIM; write
// only while idle. cfg_ready_o is always high.
// Output beat (valid/ready): one result per input beat, in order.
// Path: a clear or a beat that closes no group is registered in the datapath,
// then loaded into the output register; a beat that closes a group first runs
// the restoring divider for SUM_W quotient bits, one quotient bit per cycle (SUM_W =
// 17 + clog2(MAX_DECIM), 21 at the default). One beat is in flight at a time; the next
// beat is taken as soon as the previous one has reached the output register.
// Stall: a result held in the output register does not block acceptance, but
// the following result waits until the held one is taken.
// Reset: filter, accumulator and output valid clear, decim_factor returns to 2.
module mic_dc_block_decimator import mdb_pkg::*; #(
  parameter int unsigned MAX_DECIM = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [DECIM_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  localparam int unsigned SUM_W  = PCM_W + 1 + $clog2(MAX_DECIM);
  localparam int unsigned CNT_RW = $clog2(MAX_DECIM + 1);
  localparam int unsigned CNT_W  = (CNT_RW > DECIM_W) ? CNT_RW : DECIM_W;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  mdb_ctrl #(
    .SUM_W(SUM_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mdb_datapath #(
    .MAX_DECIM(MAX_DECIM),
    .SUM_W    (SUM_W),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/mdb_checker.sv =====
module mdb_checker import mdb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in flight");

  a_rose_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("output beat appeared without work in progress");

  a_no_group_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.decim_valid |-> out_data_o.decim_sample == '0)
    else $error("decim_sample nonzero without a completed group");

endmodule

bind mic_dc_block_decimator mdb_checker u_mdb_checker (.*);

// ===== tb/dc_decim_checker.sv =====
`timescale 1ns / 1ps

module dc_decim_checker import mdb_pkg::*; #(
  parameter int unsigned MAX_DECIM = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [DECIM_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_t               out_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 beats_o,
  output int                 groups_o,
  output int                 clears_o
);

  logic signed [PCM_W-1:0] x_prev;
  logic signed [FB_W-1:0]  y_prev;
  logic signed [23:0]      acc_sum;
  logic [DECIM_W-1:0]      acc_cnt;
  logic [DECIM_W-1:0]      factor_reg;
  out_t                    decim_out_q[$];

  function automatic longint clamp16(longint v);
    if (v > PCM_MAX) return PCM_MAX;
    if (v < PCM_MIN) return PCM_MIN;
    return v;
  endfunction

  function automatic out_t dc_block_decimate(in_t beat);
    out_t        r;
    longint      pcm;
    longint      y1;
    longint      y;
    longint      filt;
    longint      avg;
    int unsigned eff;
    int          cnt;
    r = '0;
    if (beat.action == ACT_CLEAR) begin
      x_prev  = '0;
      y_prev  = '0;
      acc_sum = '0;
      acc_cnt = '0;
      return r;
    end
    pcm = clamp16(longint'(beat.raw_word) >>> 16);
    y1 = longint'(y_prev);
    y = pcm - longint'(x_prev) + y1 - (y1 >>> FB_SHIFT);
    x_prev = pcm[PCM_W-1:0];
    y_prev = y[FB_W-1:0];
    filt = clamp16(longint'(y_prev));
    acc_sum = acc_sum + filt[23:0];
    acc_cnt = acc_cnt + 1'b1;
    eff = factor_reg;
    if (eff < 1) eff = 1;
    if (eff > MAX_DECIM) eff = MAX_DECIM;
    r.pcm_sample = pcm[PCM_W-1:0];
    if (acc_cnt >= eff || acc_cnt == 0) begin
      cnt = (acc_cnt == 0) ? 32 : int'(acc_cnt);
      avg = clamp16(longint'(acc_sum) / cnt);
      r.decim_valid  = 1'b1;
      r.decim_sample = avg[PCM_W-1:0];
      acc_sum = '0;
      acc_cnt = '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      x_prev     = '0;
      y_prev     = '0;
      acc_sum    = '0;
      acc_cnt    = '0;
      factor_reg = DECIM_RESET;
      decim_out_q.delete();
      errors_o   = 0;
      pending_o  = 0;
      beats_o    = 0;
      groups_o   = 0;
      clears_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        beats_o++;
        if (decim_out_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected beat pcm=%0d valid=%0b decim=%0d", $time,
                   got.pcm_sample, got.decim_valid, got.decim_sample);
        end else begin
          want = decim_out_q.pop_front();
          if (got.decim_valid === 1'b1) groups_o++;
          if (got.pcm_sample !== want.pcm_sample ||
              got.decim_valid !== want.decim_valid ||
              got.decim_sample !== want.decim_sample) begin
            errors_o++;
            $display("%0t: mismatch exp pcm=%0d valid=%0b decim=%0d,",
                     $time, want.pcm_sample, want.decim_valid, want.decim_sample);
            $display("%0t:          got pcm=%0d valid=%0b decim=%0d",
                     $time, got.pcm_sample, got.decim_valid, got.decim_sample);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.action == ACT_CLEAR) clears_o++;
        decim_out_q.push_back(dc_block_decimate(in_data_i));
      end
      if (cfg_valid_i && cfg_ready_i) factor_reg = cfg_data_i;
      pending_o = decim_out_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mdb_pkg::*;

  localparam int unsigned MAX_DECIM     = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_BEATS   = 190;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam logic        ACT_SAMPLE    = 1'b0;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DECIM_W-1:0] cfg_data = DECIM_RESET;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;

  int errors;
  int pending;
  int beats;
  int groups;
  int clears;
  int cycles = 0;
  int factor_writes = 0;
  bit burst_mode = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mic_dc_block_decimator #(.MAX_DECIM(MAX_DECIM)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  dc_decim_checker #(.MAX_DECIM(MAX_DECIM)) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .beats_o     (beats),
    .groups_o    (groups),
    .clears_o    (clears)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_t make_beat(logic act, logic [RAW_W-1:0] raw);
    in_t b;
    b.action   = act;
    b.raw_word = raw;
    return b;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw(int dc);
    int               level;
    logic [RAW_W-1:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: r = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2, 3: ;
      default: begin
        level = dc + int'($urandom_range(0, 6000)) - 3000;
        if (level > PCM_MAX) level = PCM_MAX;
        if (level < PCM_MIN) level = PCM_MIN;
        r[31:16] = level[15:0];
      end
    endcase
    return r;
  endfunction

  function automatic logic [DECIM_W-1:0] phase_factor(int p);
    case (p)
      0: return 5'd1;
      1: return 5'd16;
      2: return 5'd31;
      3: return 5'd0;
      4: return 5'd4;
      default: return DECIM_W'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic offer_sample(in_t beat);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // drain, let the divider settle, then write the factor
  task automatic write_factor(logic [DECIM_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    factor_writes++;
  endtask

  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 6);
      if (taken == 60 || taken == 900) stall = 400;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    int dc_level;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    offer_sample(make_beat(ACT_SAMPLE, 32'h7FFF_FFFF));
    offer_sample(make_beat(ACT_SAMPLE, 32'h8000_0000));
    offer_sample(make_beat(ACT_SAMPLE, 32'h7FFF_0000));
    offer_sample(make_beat(ACT_SAMPLE, 32'hFFFF_FFFF));
    offer_sample(make_beat(ACT_SAMPLE, 32'h0000_FFFF));
    offer_sample(make_beat(ACT_SAMPLE, 32'h0001_0000));
    offer_sample(make_beat(ACT_CLEAR, $urandom()));
    offer_sample(make_beat(ACT_CLEAR, $urandom()));
    // full-scale square wave drives the feedback hard into saturation
    for (int i = 0; i < 6; i++)
      offer_sample(make_beat(ACT_SAMPLE, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF));

    write_factor(5'd16);
    for (int i = 0; i < 5; i++) offer_sample(make_beat(ACT_SAMPLE, pick_raw(0)));
    // lower the factor under a partly filled group
    write_factor(5'd3);
    for (int i = 0; i < 2; i++) offer_sample(make_beat(ACT_SAMPLE, pick_raw(0)));
    write_factor(5'd0);
    for (int i = 0; i < 2; i++) offer_sample(make_beat(ACT_SAMPLE, pick_raw(0)));
    write_factor(5'd31);
    for (int i = 0; i < 2; i++) offer_sample(make_beat(ACT_SAMPLE, pick_raw(0)));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_factor(phase_factor(p));
      dc_level = int'($urandom_range(0, 40000)) - 20000;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        burst_mode = (k >= 40 && k < 75);
        if ($urandom_range(0, 24) == 0)
          offer_sample(make_beat(ACT_CLEAR, $urandom()));
        else
          offer_sample(make_beat(ACT_SAMPLE, pick_raw(dc_level)));
      end
      burst_mode = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("covered %0d beats: %0d clears, %0d decimated groups, %0d factor writes",
             beats, clears, groups, factor_writes);
    $display("factors 0..31 incl. clamp ends, mid-group lowering, long output back-pressure");
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mdb_pkg.sv
hdl/mdb_datapath.sv
hdl/mdb_ctrl.sv
hdl/mic_dc_block_decimator.sv
hdl/mdb_checker.sv
tb/dc_decim_checker.sv
tb/tb.sv
